// ===== rtl/core/qrs_pkg.sv =====
package qrs_pkg;

  // port widths fixed by the channel payload
  localparam int PORT_W = 32;
  localparam int CODE_W = 3;

  // case codes
  localparam logic [CODE_W-1:0] CASE_INF  = 3'd0;
  localparam logic [CODE_W-1:0] CASE_NONE = 3'd1;
  localparam logic [CODE_W-1:0] CASE_LIN  = 3'd2;
  localparam logic [CODE_W-1:0] CASE_DBL  = 3'd3;
  localparam logic [CODE_W-1:0] CASE_TWO  = 3'd4;

  typedef struct packed {
    logic signed [PORT_W-1:0] coef_a;
    logic signed [PORT_W-1:0] coef_b;
    logic signed [PORT_W-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [CODE_W-1:0]        case_code;
    logic signed [PORT_W-1:0] root_one;
    logic signed [PORT_W-1:0] root_two;
    logic                     overflow;
  } qrs_out_t;

  // divider side information
  typedef struct packed {
    logic neg;
    logic zero;
  } qrs_div_ctl_t;

endpackage

// ===== rtl/core/qrs_in_if.sv =====
interface qrs_in_if import qrs_pkg::*; ();
  logic    valid;
  logic    ready;
  qrs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/qrs_out_if.sv =====
interface qrs_out_if import qrs_pkg::*; ();
  logic     valid;
  logic     ready;
  qrs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/qrs_div_pipe.sv =====
module qrs_div_pipe import qrs_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [W+1:0]        num_mag,
  input  logic [W:0]          den_mag,
  input  qrs_div_ctl_t        ctl,
  output logic signed [W-1:0] root,
  output logic                ovf
);

  localparam int NW = W + 2 + F;
  localparam int CW = (NW > 2 * W + 2) ? NW : 2 * W + 2;
  localparam int ST = W + 1;
  localparam logic [W:0] POS_LIM = (W+1)'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [W:0] NEG_LIM = (W+1)'(64'd1 << (W - 1));

  logic [NW-1:0] nfull;
  logic [CW-1:0] dsh;
  logic          big_c;

  logic [W:0]   rem  [0:ST];
  logic [W:0]   quo  [0:ST];
  logic [W:0]   nlo  [0:ST];
  logic [W:0]   dm   [0:ST];
  logic         big  [0:ST];
  qrs_div_ctl_t ctlp [0:ST];

  // scaled numerator and early check for a quotient beyond w+1 bits
  assign nfull = NW'(num_mag) << F;
  assign dsh   = CW'(den_mag) << (W + 1);
  assign big_c = CW'(nfull) >= dsh;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= (W+1)'(nfull >> (W + 1));
      nlo[0]  <= nfull[W:0];
      quo[0]  <= '0;
      dm[0]   <= den_mag;
      big[0]  <= big_c;
      ctlp[0] <= ctl;
    end
  end

  // one restoring step per stage
  for (genvar j = 1; j <= ST; j++) begin : g_step
    logic [W+1:0] rem2;
    logic         ge;
    assign rem2 = {rem[j-1], nlo[j-1][W]};
    assign ge   = rem2 >= (W+2)'(dm[j-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= ge ? (W+1)'(rem2 - (W+2)'(dm[j-1])) : (W+1)'(rem2);
        quo[j]  <= {quo[j-1][W-1:0], ge};
        nlo[j]  <= nlo[j-1] << 1;
        dm[j]   <= dm[j-1];
        big[j]  <= big[j-1];
        ctlp[j] <= ctlp[j-1];
      end
    end
  end

  // saturation and sign
  logic       sat;
  logic [W:0] mag;
  always_comb begin
    sat = big[ST] || (!ctlp[ST].neg && quo[ST] > POS_LIM)
                  || (ctlp[ST].neg && quo[ST] > NEG_LIM);
    mag = sat ? (ctlp[ST].neg ? NEG_LIM : POS_LIM) : quo[ST];
    if (ctlp[ST].zero) begin
      root = '0;
      ovf  = 1'b0;
    end else begin
      root = ctlp[ST].neg ? W'(-mag) : W'(mag);
      ovf  = sat;
    end
  end

endmodule

// ===== rtl/core/quadratic_root_solver_unit.sv =====
// Quadratic root solver: real roots of a*x^2 + b*x + c = 0 in signed fixed point.
// coefs channel: one request per triple (coef_a, coef_b, coef_c), valid/ready,
// taken at a clock edge where both are high. roots channel: one result per
// request, in order, with the case code, two roots and a saturation flag.
// Stages: three for sign handling, the two products and the discriminant,
// COEF_WIDTH + 1 square root stages (two radicand bits each), one numerator
// stage, COEF_WIDTH + 2 divider stages (a loading stage, then one quotient bit
// per stage, two dividers side by side) and the output register. Throughput
// is one request per cycle while the receiver does not stall the output.
// The whole pipeline advances together whenever the output register is empty
// or being taken; while the receiver stalls with a result held, coefs.ready is
// low and every stage holds its contents. A synchronous reset clears all valid
// bits; the data registers are not reset.
module quadratic_root_solver_unit import qrs_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int COEF_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  qrs_in_if.sink    coefs,
  qrs_out_if.source roots
);

  localparam int W   = COEF_WIDTH;
  localparam int DW  = 2 * W + 2;
  localparam int RW  = W + 1;
  localparam int SQL = W + 1;
  localparam int NW0 = W + 3;
  localparam int DVL = W + 2;

  logic en;
  logic ov;

  assign en          = !ov || roots.ready;
  assign coefs.ready = en;
  assign roots.valid = ov;

  // stage 1: registered coefficients
  logic                v1;
  logic signed [W-1:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= coefs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= coefs.data.coef_a[W-1:0];
      b1 <= coefs.data.coef_b[W-1:0];
      c1 <= coefs.data.coef_c[W-1:0];
    end
  end

  // magnitudes for the products
  logic [W-1:0] am1, bm1, cm1;
  logic         acpos1;
  assign am1    = a1[W-1] ? W'(-a1) : W'(a1);
  assign bm1    = b1[W-1] ? W'(-b1) : W'(b1);
  assign cm1    = c1[W-1] ? W'(-c1) : W'(c1);
  assign acpos1 = (a1[W-1] == c1[W-1]) && (c1 != '0);

  // stage 2: b*b and a*c
  logic                v2;
  logic signed [W-1:0] a2, b2, c2;
  logic [2*W-1:0]      bsq2, pac2;
  logic                acpos2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2     <= a1;
      b2     <= b1;
      c2     <= c1;
      bsq2   <= (2*W)'(bm1) * (2*W)'(bm1);
      pac2   <= (2*W)'(am1) * (2*W)'(cm1);
      acpos2 <= acpos1;
    end
  end

  // discriminant and case decision
  logic [DW-1:0]     p4, bq, disc;
  logic              dneg;
  logic [CODE_W-1:0] code2;
  always_comb begin
    p4   = DW'(pac2) << 2;
    bq   = DW'(bsq2);
    dneg = acpos2 && (p4 > bq);
    disc = acpos2 ? bq - p4 : bq + p4;
    if (a2 == '0) begin
      if (b2 == '0) begin
        code2 = (c2 == '0) ? CASE_INF : CASE_NONE;
      end else begin
        code2 = CASE_LIN;
      end
    end else if (dneg) begin
      code2 = CASE_NONE;
    end else if (disc == '0) begin
      code2 = CASE_DBL;
    end else begin
      code2 = CASE_TWO;
    end
  end

  // square root pipeline, index 0 holds the discriminant stage
  logic                v_sq    [0:SQL];
  logic [CODE_W-1:0]   sq_code [0:SQL];
  logic signed [W-1:0] sq_a    [0:SQL];
  logic signed [W-1:0] sq_b    [0:SQL];
  logic signed [W-1:0] sq_c    [0:SQL];
  logic [DW-1:0]       sq_disc [0:SQL];
  logic [RW-1:0]       sq_root [0:SQL];
  logic [W+1:0]        sq_rem  [0:SQL];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sq[0] <= 1'b0;
    end else if (en) begin
      v_sq[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_code[0] <= code2;
      sq_a[0]    <= a2;
      sq_b[0]    <= b2;
      sq_c[0]    <= c2;
      sq_disc[0] <= disc;
      sq_root[0] <= '0;
      sq_rem[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= SQL; k++) begin : g_sqrt
    logic [W+3:0] rem4;
    logic [W+2:0] trial;
    logic         ge;
    assign rem4  = {sq_rem[k-1], sq_disc[k-1][DW-1:DW-2]};
    assign trial = {sq_root[k-1], 2'b01};
    assign ge    = rem4 >= (W+4)'(trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_sq[k] <= 1'b0;
      end else if (en) begin
        v_sq[k] <= v_sq[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k]  <= ge ? (W+2)'(rem4 - (W+4)'(trial)) : (W+2)'(rem4);
        sq_root[k] <= {sq_root[k-1][RW-2:0], ge};
        sq_disc[k] <= sq_disc[k-1] << 2;
        sq_code[k] <= sq_code[k-1];
        sq_a[k]    <= sq_a[k-1];
        sq_b[k]    <= sq_b[k-1];
        sq_c[k]    <= sq_c[k-1];
      end
    end
  end

  // numerators and denominator
  logic signed [NW0-1:0] t_b, t_nb, t_s, t_a2, t_nc, t_n1, t_n2, t_den;
  qrs_div_ctl_t          ctl1_c, ctl2_c;
  logic                  none_c;
  always_comb begin
    t_b    = NW0'(sq_b[SQL]);
    t_nb   = -t_b;
    t_s    = NW0'(sq_root[SQL]);
    t_a2   = NW0'(sq_a[SQL]) <<< 1;
    t_nc   = -NW0'(sq_c[SQL]);
    none_c = (sq_code[SQL] == CASE_INF) || (sq_code[SQL] == CASE_NONE);
    if (sq_code[SQL] == CASE_LIN) begin
      t_n1  = t_nc;
      t_n2  = t_nc;
      t_den = t_b;
    end else begin
      t_n1  = t_nb + t_s;
      t_n2  = t_nb - t_s;
      t_den = t_a2;
    end
    ctl1_c.neg  = t_n1[NW0-1] ^ t_den[NW0-1];
    ctl1_c.zero = none_c || (t_n1 == '0) || (t_den == '0);
    ctl2_c.neg  = t_n2[NW0-1] ^ t_den[NW0-1];
    ctl2_c.zero = none_c || (t_n2 == '0) || (t_den == '0);
  end

  // numerator stage: divider operands
  logic              v4;
  logic [CODE_W-1:0] code4;
  logic [W+1:0]      nm1, nm2;
  logic [W:0]        dm4;
  qrs_div_ctl_t      ctl1, ctl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v_sq[SQL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code4 <= sq_code[SQL];
      nm1   <= t_n1[NW0-1] ? (W+2)'(-t_n1) : (W+2)'(t_n1);
      nm2   <= t_n2[NW0-1] ? (W+2)'(-t_n2) : (W+2)'(t_n2);
      dm4   <= t_den[NW0-1] ? (W+1)'(-t_den) : (W+1)'(t_den);
      ctl1  <= ctl1_c;
      ctl2  <= ctl2_c;
    end
  end

  // two dividers side by side
  logic signed [W-1:0] r1, r2;
  logic                o1, o2;

  qrs_div_pipe #(.W(W), .F(FRAC_BITS)) u_div_one (
    .clk     (clk),
    .en      (en),
    .num_mag (nm1),
    .den_mag (dm4),
    .ctl     (ctl1),
    .root    (r1),
    .ovf     (o1)
  );

  qrs_div_pipe #(.W(W), .F(FRAC_BITS)) u_div_two (
    .clk     (clk),
    .en      (en),
    .num_mag (nm2),
    .den_mag (dm4),
    .ctl     (ctl2),
    .root    (r2),
    .ovf     (o2)
  );

  // case code and valid alongside the dividers
  logic              v_dv    [0:DVL-1];
  logic [CODE_W-1:0] dv_code [0:DVL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dv[0] <= 1'b0;
    end else if (en) begin
      v_dv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_code[0] <= code4;
    end
  end

  for (genvar j = 1; j < DVL; j++) begin : g_dvctx
    always_ff @(posedge clk) begin
      if (rst) begin
        v_dv[j] <= 1'b0;
      end else if (en) begin
        v_dv[j] <= v_dv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_code[j] <= dv_code[j-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= v_dv[DVL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roots.data.case_code <= dv_code[DVL-1];
      roots.data.root_one  <= PORT_W'(r1);
      roots.data.root_two  <= PORT_W'(r2);
      roots.data.overflow  <= o1 | o2;
    end
  end

`ifndef SYNTH
  // no root or infinite solutions carry zero roots and no flag
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    roots.valid && (roots.data.case_code == CASE_INF || roots.data.case_code == CASE_NONE)
      |-> roots.data.root_one == '0 && roots.data.root_two == '0 && !roots.data.overflow)
    else $error("empty case with nonzero roots");

  // only the two-root case may differ between roots
  a_roots_equal: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.data.case_code != CASE_TWO
      |-> roots.data.root_one == roots.data.root_two)
    else $error("roots differ outside the two-root case");

  // a held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    roots.valid && !roots.ready |-> !coefs.ready)
    else $error("request taken during output stall");
`endif

endmodule
